// ===== design/elmdc_pkg.sv =====
// types, codes and helpers shared by the endstop learning motor drive controller
package elmdc_pkg;

    localparam int LvlW = 12;
    localparam logic [LvlW-1:0] LearnDelta = 12'd20;
    localparam logic [LvlW:0] BandGuard = 13'd20;
    localparam logic [1:0] ArriveDebounce = 2'd3;

    typedef enum logic [1:0] {
        TGT_STOP   = 2'd0,
        TGT_OPEN   = 2'd1,
        TGT_CLOSED = 2'd2
    } target_t;

    typedef enum logic [2:0] {
        ACT_HOLD    = 3'd0,
        ACT_START   = 3'd1,
        ACT_REVERSE = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_ARRIVED = 3'd4,
        ACT_RETRY   = 3'd5,
        ACT_GIVEUP  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        CLS_INVALID = 2'd0,
        CLS_OPEN    = 2'd1,
        CLS_CLOSED  = 2'd2,
        CLS_TRANSIT = 2'd3
    } hall_class_t;

    typedef enum logic [2:0] {
        REG_SETTLE_DELTA    = 3'd0,
        REG_SETTLE_TICKS    = 3'd1,
        REG_MOVED_DELTA     = 3'd2,
        REG_STUCK_TICKS     = 3'd3,
        REG_MIN_SEPARATION  = 3'd4,
        REG_CLASSIFY_MARGIN = 3'd5,
        REG_VERIFY_TICKS    = 3'd6,
        REG_MAX_RETRIES     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [1:0]      applied_target;
        logic [1:0]      drive_direction;
        logic            is_running;
        logic [2:0]      retry_counter;
        logic [1:0]      inband_count;
        logic            arrived_latch;
        logic            gaveup_latch;
        logic [9:0]      drive_tick_count;
        logic [LvlW-1:0] start_level;
        logic [LvlW-1:0] settle_reference;
        logic [7:0]      stable_count;
        logic            moved_flag;
        logic            open_learned;
        logic [LvlW-1:0] open_level;
        logic            closed_learned;
        logic [LvlW-1:0] closed_level;
        logic [LvlW-1:0] last_sample;
    } grp_ctx_t;

    function automatic logic [LvlW-1:0] abs_diff(input logic [LvlW-1:0] a,
                                                 input logic [LvlW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

// ===== design/endstop_learning_motor_drive_ctrl.sv =====
// top level of the endstop learning motor drive controller
// the input transaction passes through the input register and then the result register
// throughput: one transaction per cycle while out_stall is low (single per-group state update)
// per-group state is read and written in the same cycle, so back-to-back ticks see it
// reset: all groups stopped, levels unlearned, registers at their default values
// cfg_ready is always high; configuration takes effect on the next transaction
module endstop_learning_motor_drive_ctrl
    import elmdc_pkg::*;
#(
    parameter int GROUPS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  group,
    input  logic [1:0]  target_cmd,
    input  logic [11:0] hall_mv,
    input  logic        sample_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  drive_dir,
    output logic [2:0]  action,
    output logic [1:0]  hall_class,
    output logic        running,
    output logic        save_request,
    output logic        saved_endstop,
    output logic [11:0] saved_level,
    output logic [2:0]  retry_count,
    output logic        gave_up_flag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int IdxW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic [9:0]  settle_delta_reg;
    logic [7:0]  settle_ticks_reg;
    logic [11:0] moved_delta_reg;
    logic [7:0]  stuck_ticks_reg;
    logic [11:0] min_separation_reg;
    logic [10:0] classify_margin_reg;
    logic [9:0]  verify_ticks_reg;
    logic [2:0]  max_retries_reg;

    logic        in_full_reg;
    logic [1:0]  group_reg;
    logic [1:0]  target_reg;
    logic [11:0] hall_reg;
    logic        ok_reg;

    grp_ctx_t state_reg [GROUPS];
    grp_ctx_t cur;
    grp_ctx_t nxt;

    logic        out_valid_reg;
    logic [1:0]  drive_dir_reg;
    logic [2:0]  action_reg;
    logic [1:0]  hall_class_reg;
    logic        running_reg;
    logic        save_request_reg;
    logic        saved_endstop_reg;
    logic [11:0] saved_level_reg;
    logic [2:0]  retry_count_reg;
    logic        gave_up_flag_reg;

    logic           res_free;
    logic           fire;
    logic           in_range;
    logic [IdxW-1:0] gidx;
    logic [1:0]     want;
    logic [11:0]    mv;
    logic [1:0]     cls;
    logic [2:0]     act;
    logic           save;
    logic [11:0]    margin;
    logic [12:0]    half;
    logic [11:0]    lv_diff;
    logic           in_band;
    logic           wait_db;
    logic           seated;
    logic           learn_ok;
    logic [1:0]     inband_inc;
    logic [11:0]    own_lv;
    logic [11:0]    other_lv;
    logic           own_ok;
    logic           other_ok;

    assign cfg_ready = 1'b1;
    assign res_free  = !out_valid_reg || !out_stall;
    assign in_stall  = in_full_reg && !res_free;
    assign fire      = in_full_reg && res_free;
    assign in_range  = 32'(group_reg) < GROUPS;
    assign gidx      = IdxW'(group_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_delta_reg    <= 10'd45;
            settle_ticks_reg    <= 8'd6;
            moved_delta_reg     <= 12'd200;
            stuck_ticks_reg     <= 8'd35;
            min_separation_reg  <= 12'd300;
            classify_margin_reg <= 11'd250;
            verify_ticks_reg    <= 10'd120;
            max_retries_reg     <= 3'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SETTLE_DELTA:    settle_delta_reg    <= cfg_data[9:0];
                REG_SETTLE_TICKS:    settle_ticks_reg    <= cfg_data[7:0];
                REG_MOVED_DELTA:     moved_delta_reg     <= cfg_data;
                REG_STUCK_TICKS:     stuck_ticks_reg     <= cfg_data[7:0];
                REG_MIN_SEPARATION:  min_separation_reg  <= cfg_data;
                REG_CLASSIFY_MARGIN: classify_margin_reg <= cfg_data[10:0];
                REG_VERIFY_TICKS:    verify_ticks_reg    <= cfg_data[9:0];
                REG_MAX_RETRIES:     max_retries_reg     <= cfg_data[2:0];
                default:             max_retries_reg     <= max_retries_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            group_reg  <= group;
            target_reg <= target_cmd;
            hall_reg   <= hall_mv;
            ok_reg     <= sample_ok;
        end
    end

    // per-group update
    always_comb
    begin
        cur        = state_reg[gidx];
        nxt        = cur;
        want       = (target_reg == TGT_CLOSED || target_reg == TGT_OPEN) ?
                     target_reg : TGT_STOP;
        act        = ACT_HOLD;
        save       = 1'b0;
        cls        = CLS_INVALID;
        in_band    = 1'b0;
        wait_db    = 1'b0;
        seated     = 1'b0;
        learn_ok   = 1'b0;
        inband_inc = cur.inband_count + 2'd1;

        lv_diff = abs_diff(cur.open_level, cur.closed_level);
        half    = {2'b00, lv_diff[11:1]} - BandGuard;
        margin  = {1'b0, classify_margin_reg};
        if (cur.open_learned && cur.closed_learned && !half[12] && half != 13'd0 &&
            half < {2'b00, classify_margin_reg})
        begin
            margin = half[11:0];
        end

        if (ok_reg)
        begin
            nxt.last_sample = hall_reg;
            if (hall_reg == 12'd0)
                cls = CLS_INVALID;
            else if (cur.open_learned && abs_diff(hall_reg, cur.open_level) <= margin)
                cls = CLS_OPEN;
            else if (cur.closed_learned && abs_diff(hall_reg, cur.closed_level) <= margin)
                cls = CLS_CLOSED;
            else
                cls = CLS_TRANSIT;
        end
        mv = nxt.last_sample;

        own_ok   = (want == TGT_OPEN) ? cur.open_learned : cur.closed_learned;
        own_lv   = (want == TGT_OPEN) ? cur.open_level : cur.closed_level;
        other_ok = (want == TGT_OPEN) ? cur.closed_learned : cur.open_learned;
        other_lv = (want == TGT_OPEN) ? cur.closed_level : cur.open_level;

        if (want == TGT_STOP)
        begin
            if (cur.is_running)
                act = ACT_STOP;
            nxt.drive_direction = 2'd0;
            nxt.is_running      = 1'b0;
            nxt.applied_target  = TGT_STOP;
            nxt.retry_counter   = 3'd0;
            nxt.inband_count    = 2'd0;
            nxt.arrived_latch   = 1'b0;
            nxt.gaveup_latch    = 1'b0;
        end
        else if (cur.applied_target != want || (!cur.arrived_latch &&
                 !cur.gaveup_latch && !cur.is_running))
        begin
            if (cur.applied_target != want)
            begin
                nxt.retry_counter = 3'd0;
                nxt.gaveup_latch  = 1'b0;
                nxt.arrived_latch = 1'b0;
            end
            act = (cur.drive_direction != 2'd0 && cur.drive_direction != want) ?
                  ACT_REVERSE : ACT_START;
            nxt.drive_direction  = want;
            nxt.applied_target   = want;
            nxt.is_running       = 1'b1;
            nxt.drive_tick_count = 10'd0;
            nxt.start_level      = mv;
            nxt.settle_reference = mv;
            nxt.stable_count     = 8'd0;
            nxt.moved_flag       = 1'b0;
            nxt.inband_count     = 2'd0;
        end
        else if (cur.arrived_latch || cur.gaveup_latch)
        begin
            act = ACT_HOLD;
        end
        else
        begin
            if (abs_diff(mv, cur.settle_reference) <= {2'b00, settle_delta_reg})
            begin
                if (cur.stable_count != 8'hff)
                    nxt.stable_count = cur.stable_count + 8'd1;
            end
            else
            begin
                nxt.settle_reference = mv;
                nxt.stable_count     = 8'd0;
            end
            if (abs_diff(mv, cur.start_level) > moved_delta_reg)
                nxt.moved_flag = 1'b1;
            if (cur.drive_tick_count != 10'h3ff)
                nxt.drive_tick_count = cur.drive_tick_count + 10'd1;

            in_band = (cls == want);
            if (in_band)
            begin
                nxt.inband_count = inband_inc;
                wait_db = inband_inc < ArriveDebounce;
            end
            else
            begin
                nxt.inband_count = 2'd0;
            end

            if (!wait_db)
            begin
                seated = (nxt.stable_count >= settle_ticks_reg) &&
                         (nxt.moved_flag || nxt.drive_tick_count >= {2'b00, stuck_ticks_reg});
                if (in_band || seated)
                begin
                    learn_ok = (mv != 12'd0) &&
                               !(other_ok && abs_diff(mv, other_lv) < min_separation_reg) &&
                               !(own_ok && abs_diff(mv, own_lv) <= LearnDelta);
                    if (learn_ok)
                    begin
                        save = 1'b1;
                        if (want == TGT_OPEN)
                        begin
                            nxt.open_learned = 1'b1;
                            nxt.open_level   = mv;
                        end
                        else
                        begin
                            nxt.closed_learned = 1'b1;
                            nxt.closed_level   = mv;
                        end
                    end
                    nxt.drive_direction = 2'd0;
                    nxt.is_running      = 1'b0;
                    nxt.arrived_latch   = 1'b1;
                    nxt.retry_counter   = 3'd0;
                    act = ACT_ARRIVED;
                end
                else if (nxt.drive_tick_count >= verify_ticks_reg)
                begin
                    if (cur.retry_counter < max_retries_reg)
                    begin
                        nxt.retry_counter    = cur.retry_counter + 3'd1;
                        nxt.drive_direction  = want;
                        nxt.is_running       = 1'b1;
                        nxt.drive_tick_count = 10'd0;
                        nxt.start_level      = mv;
                        nxt.settle_reference = mv;
                        nxt.stable_count     = 8'd0;
                        nxt.moved_flag       = 1'b0;
                        nxt.inband_count     = 2'd0;
                        act = ACT_RETRY;
                    end
                    else
                    begin
                        nxt.drive_direction = 2'd0;
                        nxt.is_running      = 1'b0;
                        nxt.gaveup_latch    = 1'b1;
                        act = ACT_GIVEUP;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (fire && in_range)
        begin
            state_reg[gidx] <= nxt;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (in_range)
            begin
                drive_dir_reg     <= nxt.drive_direction;
                action_reg        <= act;
                hall_class_reg    <= cls;
                running_reg       <= nxt.is_running;
                save_request_reg  <= save;
                saved_endstop_reg <= save && (want == TGT_CLOSED);
                saved_level_reg   <= save ? mv : 12'd0;
                retry_count_reg   <= nxt.retry_counter;
                gave_up_flag_reg  <= nxt.gaveup_latch;
            end
            else
            begin
                drive_dir_reg     <= 2'd0;
                action_reg        <= ACT_HOLD;
                hall_class_reg    <= CLS_INVALID;
                running_reg       <= 1'b0;
                save_request_reg  <= 1'b0;
                saved_endstop_reg <= 1'b0;
                saved_level_reg   <= 12'd0;
                retry_count_reg   <= 3'd0;
                gave_up_flag_reg  <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_dir     = drive_dir_reg;
    assign action        = action_reg;
    assign hall_class    = hall_class_reg;
    assign running       = running_reg;
    assign save_request  = save_request_reg;
    assign saved_endstop = saved_endstop_reg;
    assign saved_level   = saved_level_reg;
    assign retry_count   = retry_count_reg;
    assign gave_up_flag  = gave_up_flag_reg;

endmodule
